// File: hdl/mx4inv_pkg.sv
// Shared types, sizes and index helpers for the 4x4 matrix inverse unit.
// No dependencies; every other file of the block imports this package.
package mx4inv_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // cofactor: six triple products, magnitude below 2^(3*VALUE_WIDTH)
    localparam int CW    = 3 * VALUE_WIDTH + 4;
    // determinant: four element * cofactor products
    localparam int DW    = 4 * VALUE_WIDTH + 4;
    // numerator |C| << 2*FRAC_BITS
    localparam int NW    = CW + 2 * FRAC_BITS;
    localparam int RW    = DW + 1;
    localparam int QW    = VALUE_WIDTH + 1;
    localparam int PW    = 2 * VALUE_WIDTH + 2;
    localparam int NCH_C = (CW + VALUE_WIDTH - 1) / VALUE_WIDTH;
    localparam int NCH_T = 2;
    localparam int CHW   = $clog2(NCH_C);
    localparam int BITW  = $clog2(NW);
    localparam int NTERM = 6;

    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        BSEL_ELEM,
        BSEL_PAIR,
        BSEL_COF
    } t_bsel;

    typedef enum logic [4:0] {
        S_LOAD,
        S_T_RX,
        S_T_RB,
        S_T_M1,
        S_T_PAIR,
        S_T_M2,
        S_T_A,
        S_C_ST,
        S_D_RX,
        S_D_M,
        S_D_A,
        S_CHK,
        S_SING,
        S_DSET,
        S_V_RD,
        S_V_LD,
        S_V_STEP,
        S_V_FIN
    } t_state;

    typedef struct packed {
        logic           load;
        logic           rd_x;
        logic           rd_b;
        logic           mul;
        t_bsel          bsel;
        logic [CHW-1:0] chunk;
        logic           top;
        logic           pair;
        logic           acc_c;
        logic           acc_d;
        logic           clr;
        logic           neg;
        logic           st_c;
        logic           rd_c;
        logic           dset;
        logic           div_ld;
        logic           div_step;
        logic           div_fin;
        logic           sing;
        logic           last;
        logic [3:0]     addr;
        logic [3:0]     caddr;
    } t_dp_cmd;

    typedef struct packed {
        logic det_zero;
        logic out_free;
    } t_dp_stat;

    // j-th of the three indexes in 0..3 that differ from ex
    function automatic logic [1:0] skip_idx(input logic [1:0] ex, input logic [1:0] j);
        return (j < ex) ? j : j + 2'd1;
    endfunction

    // column position (into the minor) used by row position pos of term tm
    function automatic logic [1:0] term_col(input logic [2:0] tm, input logic [1:0] pos);
        logic [5:0] cols;
        unique case (tm)
            3'd0:    cols = {2'd2, 2'd1, 2'd0};
            3'd1:    cols = {2'd0, 2'd2, 2'd1};
            3'd2:    cols = {2'd1, 2'd0, 2'd2};
            3'd3:    cols = {2'd0, 2'd1, 2'd2};
            3'd4:    cols = {2'd2, 2'd0, 2'd1};
            3'd5:    cols = {2'd1, 2'd2, 2'd0};
            default: cols = '0;
        endcase
        return cols[2*pos +: 2];
    endfunction

    function automatic logic term_neg(input logic [2:0] tm);
        return tm >= 3'd3;
    endfunction

    // store address of the element for cofactor ci, term tm, row position pos
    function automatic logic [3:0] elem_addr(input logic [3:0] ci, input logic [2:0] tm,
                                             input logic [1:0] pos);
        logic [1:0] r;
        logic [1:0] c;
        r = skip_idx(ci[3:2], pos);
        c = skip_idx(ci[1:0], term_col(tm, pos));
        return {r, c};
    endfunction

endpackage

// File: hdl/mx4inv_if.sv
// Valid/ready channel interfaces for the 4x4 matrix inverse unit.
// Depends on mx4inv_pkg for the value width.
interface mx4inv_in_if import mx4inv_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] element_value;

    modport source(output valid, output element_value, input ready);
    modport sink(input valid, input element_value, output ready);
endinterface

interface mx4inv_out_if import mx4inv_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] result_value;
    logic                          singular;
    logic                          last_of_run;

    modport source(output valid, output result_value, output singular,
                   output last_of_run, input ready);
    modport sink(input valid, input result_value, input singular,
                 input last_of_run, output ready);
endinterface

// File: hdl/mx4inv_dp.sv
// Datapath: element and cofactor stores, shared multiplier, accumulators,
// bit-serial divider and output register. Depends on mx4inv_pkg.
module mx4inv_dp import mx4inv_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    input  logic signed [VALUE_WIDTH-1:0] i_element,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [VALUE_WIDTH-1:0] o_result_value,
    output logic                          o_singular,
    output logic                          o_last_of_run
);

    logic signed [VALUE_WIDTH-1:0] r_elem_mem [16];
    logic signed [CW-1:0]          r_cof_mem  [16];

    logic signed [VALUE_WIDTH-1:0] r_x;
    logic signed [VALUE_WIDTH-1:0] r_b;
    logic signed [PW-1:0]          r_p;
    logic signed [2*VALUE_WIDTH-1:0] r_t;
    logic signed [CW-1:0]          r_cacc;
    logic signed [CW-1:0]          r_cof;
    logic signed [DW-1:0]          r_det;
    logic [DW-1:0]                 r_dmag;
    logic                          r_dneg;
    logic [NW-1:0]                 r_num;
    logic [RW-1:0]                 r_rem;
    logic [QW-1:0]                 r_q;
    logic                          r_big;
    logic                          r_qneg;
    logic                          r_out_valid;
    logic [VALUE_WIDTH-1:0]        r_out_val;
    logic                          r_out_sing;
    logic                          r_out_last;

    logic [VALUE_WIDTH-1:0]          w_chunk;
    logic signed [VALUE_WIDTH:0]     w_ma;
    logic signed [VALUE_WIDTH:0]     w_mb;
    logic signed [NCH_C*VALUE_WIDTH-1:0] w_cof_ext;
    logic signed [DW-1:0]            w_pext;
    logic signed [DW-1:0]            w_addend;
    logic signed [CW-1:0]            w_add_c;
    logic signed [CW-1:0]            n_cacc;
    logic signed [DW-1:0]            n_det;
    logic [CW-1:0]                   w_cmag;
    logic [RW-1:0]                   w_rs;
    logic                            w_ge;
    logic                            w_rnd;
    logic [QW:0]                     w_mag;
    logic [QW:0]                     w_lim;
    logic [VALUE_WIDTH-1:0]          w_res;

    // multiplier operand selection: low chunks unsigned, top chunk signed
    always_comb begin
        w_cof_ext = (NCH_C*VALUE_WIDTH)'(r_cof);
        unique case (i_cmd.bsel)
            BSEL_ELEM: w_chunk = r_b;
            BSEL_PAIR: w_chunk = VALUE_WIDTH'(r_t >> (VALUE_WIDTH * i_cmd.chunk));
            BSEL_COF:  w_chunk = VALUE_WIDTH'(w_cof_ext >> (VALUE_WIDTH * i_cmd.chunk));
            default:   w_chunk = '0;
        endcase
        w_ma = {r_x[VALUE_WIDTH-1], r_x};
        w_mb = i_cmd.top ? {w_chunk[VALUE_WIDTH-1], w_chunk} : {1'b0, w_chunk};
    end

    always_comb begin
        w_pext   = DW'(r_p);
        w_addend = w_pext <<< (VALUE_WIDTH * i_cmd.chunk);
        w_add_c  = CW'(w_addend);
        n_cacc   = (i_cmd.clr ? CW'(0) : r_cacc) + (i_cmd.neg ? -w_add_c : w_add_c);
        n_det    = (i_cmd.clr ? DW'(0) : r_det) + w_addend;
        w_cmag   = r_cof[CW-1] ? CW'(-r_cof) : CW'(r_cof);
    end

    // divider step and final rounding / saturation
    always_comb begin
        w_rs  = {r_rem[RW-2:0], r_num[NW-1]};
        w_ge  = w_rs >= RW'(r_dmag);
        w_rnd = {r_rem, 1'b0} >= (RW+1)'(r_dmag);
        w_mag = (QW+1)'(r_q) + (QW+1)'(w_rnd);
        w_lim = (QW+1)'(1) << (VALUE_WIDTH - 1);
        if (r_qneg) begin
            w_res = (r_big || w_mag > w_lim) ? VAL_MIN : VALUE_WIDTH'((QW+1)'(0) - w_mag);
        end else begin
            w_res = (r_big || w_mag >= w_lim) ? VAL_MAX : VALUE_WIDTH'(w_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_elem_mem[i_cmd.addr] <= i_element;
        end
        if (i_cmd.rd_x) begin
            r_x <= r_elem_mem[i_cmd.addr];
        end
        if (i_cmd.rd_b) begin
            r_b <= r_elem_mem[i_cmd.addr];
        end
        if (i_cmd.mul) begin
            r_p <= w_ma * w_mb;
        end
        if (i_cmd.pair) begin
            r_t <= r_p[2*VALUE_WIDTH-1:0];
        end
        if (i_cmd.acc_c) begin
            r_cacc <= n_cacc;
        end
        if (i_cmd.st_c) begin
            r_cof_mem[i_cmd.caddr] <= i_cmd.neg ? -r_cacc : r_cacc;
        end
        if (i_cmd.rd_c) begin
            r_cof <= r_cof_mem[i_cmd.caddr];
        end
        if (i_cmd.acc_d) begin
            r_det <= n_det;
        end
        if (i_cmd.dset) begin
            r_dneg <= r_det[DW-1];
            r_dmag <= r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        end
        if (i_cmd.div_ld) begin
            r_num  <= {w_cmag, {(2*FRAC_BITS){1'b0}}};
            r_qneg <= r_cof[CW-1] ^ r_dneg;
            r_rem  <= '0;
            r_q    <= '0;
            r_big  <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= w_ge ? w_rs - RW'(r_dmag) : w_rs;
            r_q   <= {r_q[QW-2:0], w_ge};
            r_big <= r_big | r_q[QW-1];
        end
        if (i_cmd.div_fin) begin
            r_out_val  <= w_res;
            r_out_sing <= 1'b0;
            r_out_last <= i_cmd.last;
        end else if (i_cmd.sing) begin
            r_out_val  <= '0;
            r_out_sing <= 1'b1;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.div_fin || i_cmd.sing) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.det_zero = (r_det == DW'(0));
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_out_val;
    assign o_singular      = r_out_sing;
    assign o_last_of_run   = r_out_last;

    a_sing_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sing) |-> (r_out_last && r_out_val == '0))
        else $error("singular result not a lone zero item");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < RW'(r_dmag)))
        else $error("divider remainder out of range");

    a_dmag_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dset |=> (r_dmag != '0))
        else $error("division started on zero determinant");

endmodule

// File: hdl/mx4inv_ctrl.sv
// Controller: sequences loading, cofactor terms, determinant and division.
// Depends on mx4inv_pkg; drives mx4inv_dp by command struct.
module mx4inv_ctrl import mx4inv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state         r_state, n_state;
    logic [3:0]     r_lcnt, n_lcnt;
    logic [3:0]     r_ci, n_ci;
    logic [2:0]     r_tm, n_tm;
    logic [CHW-1:0] r_ch, n_ch;
    logic [1:0]     r_di, n_di;
    logic [3:0]     r_k, n_k;
    logic [BITW-1:0] r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_lcnt  <= '0;
            r_ci    <= '0;
            r_tm    <= '0;
            r_ch    <= '0;
            r_di    <= '0;
            r_k     <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_lcnt  <= n_lcnt;
            r_ci    <= n_ci;
            r_tm    <= n_tm;
            r_ch    <= n_ch;
            r_di    <= n_di;
            r_k     <= n_k;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_lcnt     = r_lcnt;
        n_ci       = r_ci;
        n_tm       = r_tm;
        n_ch       = r_ch;
        n_di       = r_di;
        n_k        = r_k;
        n_bit      = r_bit;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.addr = r_lcnt;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (r_lcnt == 4'd15) begin
                        n_lcnt  = '0;
                        n_ci    = '0;
                        n_tm    = '0;
                        n_state = S_T_RX;
                    end else begin
                        n_lcnt = r_lcnt + 4'd1;
                    end
                end
            end
            S_T_RX: begin
                o_cmd.rd_x = 1'b1;
                o_cmd.addr = elem_addr(r_ci, r_tm, 2'd0);
                n_state    = S_T_RB;
            end
            S_T_RB: begin
                o_cmd.rd_b = 1'b1;
                o_cmd.addr = elem_addr(r_ci, r_tm, 2'd1);
                n_state    = S_T_M1;
            end
            S_T_M1: begin
                o_cmd.mul  = 1'b1;
                o_cmd.bsel = BSEL_ELEM;
                o_cmd.top  = 1'b1;
                n_state    = S_T_PAIR;
            end
            S_T_PAIR: begin
                o_cmd.pair = 1'b1;
                o_cmd.rd_x = 1'b1;
                o_cmd.addr = elem_addr(r_ci, r_tm, 2'd2);
                n_ch       = '0;
                n_state    = S_T_M2;
            end
            S_T_M2: begin
                o_cmd.mul   = 1'b1;
                o_cmd.bsel  = BSEL_PAIR;
                o_cmd.chunk = r_ch;
                o_cmd.top   = (r_ch == CHW'(NCH_T - 1));
                n_state     = S_T_A;
            end
            S_T_A: begin
                o_cmd.acc_c = 1'b1;
                o_cmd.chunk = r_ch;
                o_cmd.clr   = (r_tm == 3'd0) && (r_ch == '0);
                o_cmd.neg   = term_neg(r_tm);
                if (r_ch == CHW'(NCH_T - 1)) begin
                    if (r_tm == 3'(NTERM - 1)) begin
                        n_state = S_C_ST;
                    end else begin
                        n_tm    = r_tm + 3'd1;
                        n_state = S_T_RX;
                    end
                end else begin
                    n_ch    = r_ch + CHW'(1);
                    n_state = S_T_M2;
                end
            end
            S_C_ST: begin
                // checkerboard sign of the cofactor
                o_cmd.st_c  = 1'b1;
                o_cmd.caddr = r_ci;
                o_cmd.neg   = r_ci[2] ^ r_ci[0];
                n_tm        = '0;
                if (r_ci == 4'd15) begin
                    n_di    = '0;
                    n_state = S_D_RX;
                end else begin
                    n_ci    = r_ci + 4'd1;
                    n_state = S_T_RX;
                end
            end
            S_D_RX: begin
                o_cmd.rd_x  = 1'b1;
                o_cmd.addr  = {2'b00, r_di};
                o_cmd.rd_c  = 1'b1;
                o_cmd.caddr = {2'b00, r_di};
                n_ch        = '0;
                n_state     = S_D_M;
            end
            S_D_M: begin
                o_cmd.mul   = 1'b1;
                o_cmd.bsel  = BSEL_COF;
                o_cmd.chunk = r_ch;
                o_cmd.top   = (r_ch == CHW'(NCH_C - 1));
                n_state     = S_D_A;
            end
            S_D_A: begin
                o_cmd.acc_d = 1'b1;
                o_cmd.chunk = r_ch;
                o_cmd.clr   = (r_di == 2'd0) && (r_ch == '0);
                if (r_ch == CHW'(NCH_C - 1)) begin
                    if (r_di == 2'd3) begin
                        n_state = S_CHK;
                    end else begin
                        n_di    = r_di + 2'd1;
                        n_state = S_D_RX;
                    end
                end else begin
                    n_ch    = r_ch + CHW'(1);
                    n_state = S_D_M;
                end
            end
            S_CHK: begin
                n_state = i_stat.det_zero ? S_SING : S_DSET;
            end
            S_SING: begin
                if (i_stat.out_free) begin
                    o_cmd.sing = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_DSET: begin
                o_cmd.dset = 1'b1;
                n_k        = '0;
                n_state    = S_V_RD;
            end
            S_V_RD: begin
                // adjugate is the transposed cofactor matrix
                o_cmd.rd_c  = 1'b1;
                o_cmd.caddr = {r_k[1:0], r_k[3:2]};
                n_state     = S_V_LD;
            end
            S_V_LD: begin
                o_cmd.div_ld = 1'b1;
                n_bit        = '0;
                n_state      = S_V_STEP;
            end
            S_V_STEP: begin
                o_cmd.div_step = 1'b1;
                if (r_bit == BITW'(NW - 1)) begin
                    n_state = S_V_FIN;
                end else begin
                    n_bit = r_bit + BITW'(1);
                end
            end
            S_V_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.div_fin = 1'b1;
                    o_cmd.last    = (r_k == 4'd15);
                    if (r_k == 4'd15) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = S_V_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    a_no_take_after_16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && r_lcnt == 4'd15) |=> !o_in_ready)
        else $error("item taken right after the sixteenth element");

    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_fin || o_cmd.sing) |-> i_stat.out_free)
        else $error("output register overwritten");

    a_lcnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_lcnt == '0))
        else $error("load count not cleared during compute");

endmodule

// File: hdl/matrix4x4_inverse_unit.sv
// Top level of the 4x4 matrix inverse unit: controller plus datapath.
// Depends on mx4inv_pkg, mx4inv_if, mx4inv_ctrl and mx4inv_dp.
//
// Takes sixteen signed Q16.16 elements of a 4x4 matrix, row-major, one item
// per cycle while loading. After the sixteenth it forms the sixteen 3x3
// cofactors and the determinant exactly (no intermediate rounding), then
// returns adjugate/determinant as sixteen Q16.16 items in row-major order,
// rounded to nearest with ties away from zero, saturated to the 32-bit range,
// the last one flagged with last_of_run. A zero determinant gives a single
// item with result_value 0 and both singular and last_of_run set.
// Each cofactor takes six triple products through one 33x33 multiplier,
// then a store; the determinant follows. Each of the 16 outputs then goes
// through the restoring divider, which retires one quotient bit per cycle
// and sets the throughput. A singular matrix skips the division. The output
// register lets the next matrix load while the last result is still held.
module matrix4x4_inverse_unit import mx4inv_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mx4inv_in_if.sink     i_item,
    mx4inv_out_if.source  o_item
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    mx4inv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mx4inv_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_element      (i_item.element_value),
        .i_out_ready    (o_item.ready),
        .o_out_valid    (o_item.valid),
        .o_result_value (o_item.result_value),
        .o_singular     (o_item.singular),
        .o_last_of_run  (o_item.last_of_run)
    );

endmodule

// File: tb/matrix4x4_inverse_unit_test.sv
// Self-checking testbench for the 4x4 matrix inverse unit.
// Depends on mx4inv_pkg, mx4inv_if and matrix4x4_inverse_unit; checks every
// returned item against an exact wide-integer adjugate/determinant predictor.
module matrix4x4_inverse_unit_test;
    import mx4inv_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int WIDE         = 200;
    localparam logic [VALUE_WIDTH-1:0] ONE = 32'h0001_0000;

    typedef logic signed [WIDE-1:0] t_wide;
    typedef logic signed [VALUE_WIDTH-1:0] t_val;

    typedef struct {
        t_val value;
        logic singular;
        logic last;
    } t_inv_item;

    logic i_clk;
    logic i_rst_n;

    mx4inv_in_if  in_ch();
    mx4inv_out_if out_ch();

    matrix4x4_inverse_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (in_ch),
        .o_item (out_ch)
    );

    // predictor state
    t_val      elem_store[16];
    int        elem_count;
    t_inv_item inverse_queue[$];

    int   error_count;
    int   cycle_count;
    bit   no_idle;
    int   hold_request;
    int   hold_taken;
    int   hold_left;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("matrix4x4_inverse_unit_test failed");
            $finish;
        end
    end

    // signed cofactor of (row, col), exact
    function automatic t_wide cofactor_of(input int row, input int col);
        t_wide m[3][3];
        t_wide c;
        int ri;
        int ci;
        ri = 0;
        for (int r = 0; r < 4; r++) begin
            if (r != row) begin
                ci = 0;
                for (int k = 0; k < 4; k++) begin
                    if (k != col) begin
                        m[ri][ci] = t_wide'(elem_store[r*4+k]);
                        ci++;
                    end
                end
                ri++;
            end
        end
        c = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
          - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
          + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
        if (((row + col) & 1) != 0) c = -c;
        return c;
    endfunction

    // one accepted element; after the sixteenth, queue the inverse or a singular item
    task automatic predict_inverse(input t_val v);
        t_wide cof[16];
        t_wide det;
        logic [WIDE-1:0] dmag;
        logic [WIDE-1:0] nmag;
        logic [WIDE-1:0] q;
        logic neg;
        t_inv_item it;
        elem_store[elem_count] = v;
        if (elem_count != 15) begin
            elem_count++;
            return;
        end
        elem_count = 0;
        det = '0;
        for (int i = 0; i < 16; i++) cofactor_of_store(i, cof[i]);
        for (int i = 0; i < 4; i++) det = det + t_wide'(elem_store[i]) * cof[i];
        if (det == 0) begin
            it.value = '0;
            it.singular = 1'b1;
            it.last = 1'b1;
            inverse_queue.push_back(it);
            return;
        end
        dmag = (det < 0) ? -det : det;
        for (int k = 0; k < 16; k++) begin
            // adjugate is the cofactor matrix transposed
            t_wide c;
            c = cof[(k % 4) * 4 + k / 4];
            nmag = (c < 0) ? -c : c;
            nmag = nmag << (2 * FRAC_BITS);
            q = (2 * nmag + dmag) / (2 * dmag);
            neg = (c < 0) != (det < 0);
            if (neg) begin
                it.value = (q > (WIDE'(1) << (VALUE_WIDTH - 1))) ? VAL_MIN : t_val'(-q);
            end else begin
                it.value = (q > WIDE'(VAL_MAX)) ? VAL_MAX : t_val'(q);
            end
            it.singular = 1'b0;
            it.last = (k == 15);
            inverse_queue.push_back(it);
        end
    endtask

    task automatic cofactor_of_store(input int idx, output t_wide c);
        c = cofactor_of(idx / 4, idx % 4);
    endtask

    // result side: random ready, long hold-offs on request, compare on accept
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            if (inverse_queue.size() == 0) begin
                $display("%0t: unexpected item value=%h singular=%b last=%b", $time,
                         out_ch.result_value, out_ch.singular, out_ch.last_of_run);
                error_count++;
            end else begin
                t_inv_item e;
                e = inverse_queue.pop_front();
                if (e.value !== out_ch.result_value || e.singular !== out_ch.singular ||
                    e.last !== out_ch.last_of_run) begin
                    $display("%0t: mismatch expected %h/%b/%b got %h/%b/%b",
                             $time, e.value, e.singular, e.last, out_ch.result_value,
                             out_ch.singular, out_ch.last_of_run);
                    error_count++;
                end
            end
        end
        if (hold_request != hold_taken) begin
            hold_left = hold_request;
            hold_taken = hold_request;
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= no_idle || ($urandom_range(99) >= 34);
        end
    end

    // offer one element, idling at random first; valid stays high afterward
    task automatic send_element(input t_val v);
        while (!no_idle && $urandom_range(99) < 34) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.element_value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_inverse(v);
    endtask

    task automatic send_matrix(input t_val m[16]);
        for (int i = 0; i < 16; i++) send_element(m[i]);
    endtask

    function automatic t_val rand_small();
        // within +-4.0
        return t_val'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
    endfunction

    task automatic test_identity();
        t_val m[16];
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE : '0;
        send_matrix(m);
    endtask

    task automatic test_singular();
        t_val m[16];
        for (int i = 0; i < 16; i++) m[i] = '0;
        send_matrix(m);
        for (int i = 0; i < 16; i++) m[i] = VAL_MAX;
        send_matrix(m);
    endtask

    // diagonal of extremes and single LSBs: both saturation directions
    task automatic test_saturation();
        t_val m[16];
        for (int i = 0; i < 16; i++) m[i] = '0;
        m[0] = VAL_MIN;
        m[5] = VAL_MAX;
        m[10] = 32'sd1;
        m[15] = -32'sd1;
        send_matrix(m);
        // negative determinant with off-diagonal terms
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE : '0;
        m[0] = -ONE;
        m[1] = ONE <<< 1;
        m[14] = 32'sh0000_8000;
        send_matrix(m);
    endtask

    task automatic test_random(input int matrices);
        t_val m[16];
        int kind;
        for (int n = 0; n < matrices; n++) begin
            no_idle = (n >= matrices / 3) && (n < matrices / 2);
            kind = $urandom_range(9);
            for (int i = 0; i < 16; i++) begin
                if (kind < 2) m[i] = t_val'($urandom);
                else m[i] = rand_small();
            end
            if (kind >= 4 && kind < 6) begin
                // diagonally dominant
                for (int i = 0; i < 4; i++) m[i*5] = m[i*5] + ((m[i*5] < 0) ? -ONE * 16 : ONE * 16);
            end else if (kind >= 6 && kind < 8) begin
                // copy one row onto another: singular
                int a;
                int b;
                a = $urandom_range(3);
                b = (a + 1 + $urandom_range(2)) % 4;
                for (int k = 0; k < 4; k++) m[b*4+k] = m[a*4+k];
            end
            send_matrix(m);
        end
        no_idle = 1'b0;
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        t_val m[16];
        hold_request = 5000;
        for (int n = 0; n < 2; n++) begin
            for (int i = 0; i < 16; i++) m[i] = rand_small();
            for (int i = 0; i < 4; i++) m[i*5] = m[i*5] + ONE * 8;
            send_matrix(m);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.element_value = '0;
        elem_count = 0;
        no_idle = 1'b0;
        hold_request = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity();
        test_singular();
        test_saturation();
        test_backpressure();
        test_random(16);

        in_ch.valid <= 1'b0;
        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (error_count == 0 && inverse_queue.size() == 0) begin
            $display("matrix4x4_inverse_unit_test passed");
        end else begin
            $display("matrix4x4_inverse_unit_test failed");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/mx4inv_pkg.sv
hdl/mx4inv_if.sv
hdl/mx4inv_dp.sv
hdl/mx4inv_ctrl.sv
hdl/matrix4x4_inverse_unit.sv
tb/matrix4x4_inverse_unit_test.sv
